// ===== rtl/trk_pkg.sv =====
`default_nettype none

package trk_pkg;

	// TCP flag bits used by the handshake step
	localparam int unsigned FLAG_SYN_BIT = 1;
	localparam int unsigned FLAG_ACK_BIT = 4;

	localparam int unsigned TIME_W = 48;
	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned FLAG_W = 8;
	localparam int unsigned RETX_W = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_UPDATE
	} trk_state_t;

	// findings of one pass over the sequence table
	typedef struct packed {
		logic found;
		logic free_hit;
		logic match_hit;
	} scan_flags_t;

endpackage

`default_nettype wire

// ===== rtl/trk_ram.sv =====
`default_nettype none

module trk_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/trk_scan.sv =====
`default_nettype none

module trk_scan
	import trk_pkg::*;
#(
	parameter int unsigned IW = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clear,
	input  wire logic             chk,
	input  wire logic [IW-1:0]    chk_idx,
	input  wire logic             entry_valid,
	input  wire logic [SEQ_W-1:0] entry_seq,
	input  wire logic [SEQ_W-1:0] seq_key,
	input  wire logic [SEQ_W-1:0] ack_key,
	output scan_flags_t           flags,
	output logic      [IW-1:0]    free_idx,
	output logic      [IW-1:0]    match_idx
);
	scan_flags_t flags_q;
	logic [IW-1:0] free_idx_q;
	logic [IW-1:0] match_idx_q;
	logic hit_seq, hit_free, hit_ack;

	// compare the entry just read against both keys
	assign hit_seq  = chk && entry_valid && (seq_key != '0) && (entry_seq == seq_key);
	assign hit_free = chk && !entry_valid;
	assign hit_ack  = chk && entry_valid && (ack_key != '0) && (entry_seq == ack_key);

	// note a sequence match, and keep the first free slot and the first ack match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clear) begin
			flags_q <= '0;
		end else begin
			if (hit_seq) begin
				flags_q.found <= 1'b1;
			end
			if (hit_free) begin
				flags_q.free_hit <= 1'b1;
			end
			if (hit_ack) begin
				flags_q.match_hit <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_free && !flags_q.free_hit) begin
			free_idx_q <= chk_idx;
		end
		if (hit_ack && !flags_q.match_hit) begin
			match_idx_q <= chk_idx;
		end
	end

	assign flags     = flags_q;
	assign free_idx  = free_idx_q;
	assign match_idx = match_idx_q;

endmodule

`default_nettype wire

// ===== rtl/tcp_rtt_retransmit_tracker_unit.sv =====
// Channel   Handshake          Payload
// input     start / busy       timestamp_us, flag_byte, seq_number, ack_number
// result    done (one cycle)   handshake_rtt_us, data_rtt_us, handshake_updated,
//                              data_rtt_updated, retransmissions, duplicate_seen
//
// A packet is taken when start is high and busy is low. busy then stays high over
// one pass over the sequence memory, one entry per cycle through its registered
// read, then a send-time fetch and an update step. done is high in the first cycle
// in which busy is low again. Reset clears the table valid bits and all counters
// at once; no clearing pass. The receiver cannot stall; done is high for a single
// cycle per result.
`default_nettype none

module tcp_rtt_retransmit_tracker_unit
	import trk_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [TIME_W-1:0] timestamp_us,
	input  wire logic [FLAG_W-1:0] flag_byte,
	input  wire logic [SEQ_W-1:0]  seq_number,
	input  wire logic [SEQ_W-1:0]  ack_number,
	output logic                   done,
	output logic      [TIME_W-1:0] handshake_rtt_us,
	output logic      [TIME_W-1:0] data_rtt_us,
	output logic                   handshake_updated,
	output logic                   data_rtt_updated,
	output logic      [RETX_W-1:0] retransmissions,
	output logic                   duplicate_seen
);
	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_END = CW'(TABLE_ENTRIES);

	trk_state_t state_q, state_d;

	logic [CW-1:0]     cnt_q;
	logic              chk_s1;
	logic [IW-1:0]     chk_idx_s1;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [TIME_W-1:0] now_q;
	logic [FLAG_W-1:0] flags_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [SEQ_W-1:0]  ack_q;

	logic [TIME_W-1:0] syn_arrival_q;
	logic [TIME_W-1:0] hs_rtt_q;
	logic [TIME_W-1:0] ack_rtt_q;
	logic [RETX_W-1:0] retx_q;
	logic              dup_q;
	logic              hs_upd_q;
	logic              dr_upd_q;
	logic              done_q;

	logic              accept;
	logic              scan_clear;
	logic              issue;
	logic [IW-1:0]     seq_raddr;
	logic [SEQ_W-1:0]  seq_rdata;
	logic [TIME_W-1:0] time_rdata;
	logic              store_we;
	logic              same_pkt;
	logic              new_seq;

	scan_flags_t       scan_flags;
	logic [IW-1:0]     free_idx;
	logic [IW-1:0]     match_idx;

	logic              is_syn;
	logic              is_ack;

	assign accept     = start && (state_q == ST_IDLE);
	assign scan_clear = accept;
	assign is_syn     = flags_q[FLAG_SYN_BIT];
	assign is_ack     = flags_q[FLAG_ACK_BIT];

	// a new sequence that finds a free slot; if the ack names it, it is not stored
	assign new_seq  = (seq_q != '0) && !scan_flags.found && scan_flags.free_hit;
	assign same_pkt = new_seq && (ack_q == seq_q);

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		issue     = 1'b0;
		seq_raddr = cnt_q[IW-1:0];
		store_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == CNT_END) begin
					state_d = ST_FETCH;
				end else begin
					issue = 1'b1;
				end
			end
			ST_FETCH: begin
				store_we = new_seq && !same_pkt;
				state_d  = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan counter and read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			chk_s1 <= 1'b0;
		end else begin
			chk_s1 <= issue;
			if (accept) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= cnt_q[IW-1:0];
	end

	// latch the packet on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q   <= timestamp_us;
			flags_q <= flag_byte;
			seq_q   <= seq_number;
			ack_q   <= ack_number;
		end
	end

	// table valid bits: mark the stored slot, drop the acked slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (state_q == ST_FETCH) begin
			if (store_we) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (scan_flags.match_hit) begin
				valid_q[match_idx] <= 1'b0;
			end
		end
	end

	// session state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syn_arrival_q <= '0;
			hs_rtt_q      <= '0;
			ack_rtt_q     <= '0;
			retx_q        <= '0;
			dup_q         <= 1'b0;
			hs_upd_q      <= 1'b0;
			dr_upd_q      <= 1'b0;
			done_q        <= 1'b0;
		end else if (state_q == ST_UPDATE) begin
			done_q   <= 1'b1;
			hs_upd_q <= is_syn && is_ack;
			dr_upd_q <= scan_flags.match_hit || same_pkt;
			if (is_syn && !is_ack) begin
				syn_arrival_q <= now_q;
			end
			if (is_syn && is_ack) begin
				hs_rtt_q <= now_q - syn_arrival_q;
			end
			if ((seq_q != '0) && scan_flags.found) begin
				dup_q <= 1'b1;
				if (retx_q != '1) begin
					retx_q <= retx_q + 1'b1;
				end
			end
			if (scan_flags.match_hit) begin
				ack_rtt_q <= now_q - time_rdata;
			end else if (same_pkt) begin
				ack_rtt_q <= '0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	trk_ram #(
		.WIDTH(SEQ_W),
		.DEPTH(TABLE_ENTRIES)
	) u_seq_ram (
		.clk  (clk),
		.we   (store_we),
		.waddr(free_idx),
		.wdata(seq_q),
		.raddr(seq_raddr),
		.rdata(seq_rdata)
	);

	trk_ram #(
		.WIDTH(TIME_W),
		.DEPTH(TABLE_ENTRIES)
	) u_time_ram (
		.clk  (clk),
		.we   (store_we),
		.waddr(free_idx),
		.wdata(now_q),
		.raddr(match_idx),
		.rdata(time_rdata)
	);

	trk_scan #(
		.IW(IW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (scan_clear),
		.chk        (chk_s1),
		.chk_idx    (chk_idx_s1),
		.entry_valid(valid_q[chk_idx_s1]),
		.entry_seq  (seq_rdata),
		.seq_key    (seq_q),
		.ack_key    (ack_q),
		.flags      (scan_flags),
		.free_idx   (free_idx),
		.match_idx  (match_idx)
	);

	assign done              = done_q;
	assign handshake_rtt_us  = hs_rtt_q;
	assign data_rtt_us       = ack_rtt_q;
	assign handshake_updated = hs_upd_q;
	assign data_rtt_updated  = dr_upd_q;
	assign retransmissions   = retx_q;
	assign duplicate_seen    = dup_q;

endmodule

`default_nettype wire

// ===== rtl/trk_checker.sv =====
`default_nettype none

module trk_checker
	import trk_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire logic [RETX_W-1:0] retransmissions,
	input wire logic              duplicate_seen
);

	// a result is only shown once the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a transfer always starts work
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer did not raise busy");

	// one strobe per packet, never two in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// the duplicate flag is sticky
	a_dup_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		duplicate_seen |=> duplicate_seen)
		else $error("duplicate flag cleared");

	// the counter only moves together with a result
	a_retx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(retransmissions))
		else $error("retransmission count changed without a result");

endmodule

bind tcp_rtt_retransmit_tracker_unit trk_checker u_trk_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.retransmissions(retransmissions),
	.duplicate_seen (duplicate_seen)
);

`default_nettype wire
